// ===== rtl/core/tvsnd_pkg.sv =====
// types, register numbers and tables for the three-voice sound unit
// no dependencies; imported by three_voice_tone_noise_envelope_sound_unit
package tvsnd_pkg;

  typedef enum logic [1:0] {
    FUNC_SELECT = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  level_a;
    logic [3:0]  level_b;
    logic [3:0]  level_c;
    logic [15:0] mixed_sample;
    logic        is_active;
  } rsp_t;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned NumVoices = 3;

  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [3:0] REG_NOISE         = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_VOL_A         = 4'd8;
  localparam logic [3:0] REG_VOL_B         = 4'd9;
  localparam logic [3:0] REG_VOL_C         = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

  // bit positions in the latched shape bits and in the shape register
  localparam int unsigned ShapeHold   = 0;
  localparam int unsigned ShapeAlt    = 1;
  localparam int unsigned ShapeCont   = 2;
  localparam int unsigned ShapeAttack = 2;
  localparam int unsigned VolEnvBit   = 4;
  localparam int unsigned NoiseVoiceOfs = 3;

  localparam logic [15:0] TONE_RESET  = 16'd16;
  localparam logic [8:0]  NOISE_RESET = 9'd16;
  localparam logic [23:0] ENV_RESET   = 24'd256;
  localparam logic [16:0] NOISE_SEED  = 17'h1FFFF;
  localparam logic [3:0]  LEVEL_MAX   = 4'hF;

  // floor(x / 3) for x < 2^18 as (x * ceil(2^19 / 3)) >> 19
  localparam logic [17:0] MIX_RECIP = 18'd174763;
  localparam int unsigned MixShift  = 19;

  function automatic logic [15:0] vol_lookup(input logic [3:0] lvl);
    logic [15:0] v;
    case (lvl)
      4'd0:    v = 16'd0;
      4'd1:    v = 16'd512;
      4'd2:    v = 16'd724;
      4'd3:    v = 16'd1024;
      4'd4:    v = 16'd1448;
      4'd5:    v = 16'd2048;
      4'd6:    v = 16'd2896;
      4'd7:    v = 16'd4096;
      4'd8:    v = 16'd5793;
      4'd9:    v = 16'd8192;
      4'd10:   v = 16'd11585;
      4'd11:   v = 16'd16384;
      4'd12:   v = 16'd23170;
      4'd13:   v = 16'd32768;
      4'd14:   v = 16'd46340;
      default: v = 16'd65535;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/three_voice_tone_noise_envelope_sound_unit.sv =====
// three-voice tone, noise and envelope sound unit, top level
// depends on tvsnd_pkg for the request and response types and the volume table
//
// usage:
//   the input channel (in_valid_i, in_stall_o, in_req_i) carries requests that
//   select a register, write it, read it back or advance the chip by one tick.
//   the output channel (out_valid_o, out_stall_i, out_req_o) returns exactly one
//   response per request: read data, gated voice levels, mixed sample and the
//   active flag, in request order.
//   the chip state is updated in the cycle a request is accepted and the gated
//   levels are registered; from the level register the mix stage looks up the
//   volume table, sums the three voices and divides by three with one reciprocal
//   multiply into the output register.
//   one request is accepted per cycle while in_stall_o is low; the state update is
//   done in the accepting cycle and the mix stage has one 18x18 multiply.
//   while the receiver stalls, the response register holds and the level
//   register behind it fills, so in_stall_o rises once both are occupied.
//   reset clears the register file, sets the counters and the noise generator to
//   their power-up values and clears the valid flags; no request is in flight after reset.
module three_voice_tone_noise_envelope_sound_unit import tvsnd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_req_o
);

  function automatic logic [15:0] tone_len(input logic [7:0] fine, input logic [7:0] coarse);
    logic [11:0] p;
    p = {coarse[3:0], fine};
    if (p == 12'd0) begin
      p = 12'd1;
    end
    return {p, 4'b0000};
  endfunction

  function automatic logic [8:0] noise_len(input logic [7:0] r);
    logic [4:0] p;
    p = r[4:0];
    if (p == 5'd0) begin
      p = 5'd1;
    end
    return {p, 4'b0000};
  endfunction

  function automatic logic [23:0] env_len(input logic [7:0] fine, input logic [7:0] coarse);
    logic [15:0] p;
    p = {coarse, fine};
    if (p == 16'd0) begin
      p = 16'd1;
    end
    return {p, 8'h00};
  endfunction

  logic [7:0]  regs_q [NumRegs];
  logic [7:0]  regs_d [NumRegs];
  logic [3:0]  sel_reg_q, sel_reg_d;
  logic        sel_valid_q, sel_valid_d;
  logic        active_q, active_d;
  logic [15:0] tone_count_q [NumVoices];
  logic [15:0] tone_count_d [NumVoices];
  logic [2:0]  tone_bit_q, tone_bit_d;
  logic [8:0]  noise_count_q, noise_count_d;
  logic [16:0] noise_shift_q, noise_shift_d;
  logic        noise_bit_q, noise_bit_d;
  logic [23:0] env_count_q, env_count_d;
  logic [3:0]  env_level_q, env_level_d;
  logic        env_rising_q, env_rising_d;
  logic [2:0]  env_shape_q, env_shape_d;
  logic        env_frozen_q, env_frozen_d;

  logic        in_accept;
  logic        do_tick;
  logic        do_write;
  logic [7:0]  wr_val;
  logic [7:0]  rd_val;
  logic [3:0]  lvl_d [NumVoices];

  logic        s1_valid_q;
  logic        s1_advance;
  logic [7:0]  s1_rd_q;
  logic [3:0]  s1_lvl_q [NumVoices];
  logic        s1_active_q;

  logic        out_valid_q;
  rsp_t        out_q;
  logic [17:0] mix_sum;
  logic [35:0] mix_prod;

  assign s1_advance = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign do_tick    = in_accept && (in_req_i.func == FUNC_TICK);
  assign do_write   = in_accept && (in_req_i.func == FUNC_WRITE) && sel_valid_q;

  // register file, selection and read path
  always_comb begin
    regs_d      = regs_q;
    sel_reg_d   = sel_reg_q;
    sel_valid_d = sel_valid_q;
    active_d    = active_q;
    rd_val      = 8'h00;
    wr_val      = in_req_i.write_data;
    if (sel_reg_q inside {REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE,
                          REG_ENV_SHAPE}) begin
      wr_val = {4'h0, in_req_i.write_data[3:0]};
    end else if (sel_reg_q inside {REG_NOISE, REG_VOL_A, REG_VOL_B, REG_VOL_C}) begin
      wr_val = {3'b000, in_req_i.write_data[4:0]};
    end
    if (in_accept) begin
      case (in_req_i.func)
        FUNC_SELECT: begin
          sel_reg_d   = in_req_i.reg_addr;
          sel_valid_d = 1'b1;
          active_d    = 1'b1;
        end
        FUNC_WRITE: begin
          if (sel_valid_q) begin
            regs_d[sel_reg_q] = wr_val;
            active_d          = 1'b1;
          end
        end
        FUNC_READ: begin
          if (sel_valid_q) begin
            rd_val = regs_q[sel_reg_q];
          end
        end
        default: ;
      endcase
    end
  end

  // tone and noise generators
  always_comb begin
    logic fb;
    for (int c = 0; c < NumVoices; c++) begin
      tone_count_d[c] = tone_count_q[c];
      tone_bit_d[c]   = tone_bit_q[c];
      if (do_tick) begin
        if (tone_count_q[c] > 16'd1) begin
          tone_count_d[c] = tone_count_q[c] - 16'd1;
        end else begin
          tone_count_d[c] = tone_len(regs_d[4'(2*c)], regs_d[4'(2*c+1)]);
          tone_bit_d[c]   = !tone_bit_q[c];
        end
      end
      if (do_write && sel_reg_q <= REG_TONE_C_COARSE && sel_reg_q[3:1] == 3'(c)) begin
        tone_count_d[c] = tone_len(regs_d[4'(2*c)], regs_d[4'(2*c+1)]);
        tone_bit_d[c]   = 1'b1;
      end
    end

    fb            = noise_shift_q[0] ^ noise_shift_q[3];
    noise_count_d = noise_count_q;
    noise_shift_d = noise_shift_q;
    noise_bit_d   = noise_bit_q;
    if (do_tick) begin
      if (noise_count_q > 9'd1) begin
        noise_count_d = noise_count_q - 9'd1;
      end else begin
        noise_count_d = noise_len(regs_d[REG_NOISE]);
        noise_shift_d = {fb, noise_shift_q[16:1]};
        noise_bit_d   = noise_shift_q[1];
      end
    end
    if (do_write && sel_reg_q == REG_NOISE) begin
      noise_count_d = noise_len(regs_d[REG_NOISE]);
      noise_shift_d = NOISE_SEED;
    end
  end

  // envelope generator
  always_comb begin
    logic attack;
    logic dir;
    attack       = regs_q[REG_ENV_SHAPE][ShapeAttack];
    dir          = env_rising_q;
    env_count_d  = env_count_q;
    env_level_d  = env_level_q;
    env_rising_d = env_rising_q;
    env_shape_d  = env_shape_q;
    env_frozen_d = env_frozen_q;
    if (do_tick) begin
      if (env_count_q > 24'd1) begin
        env_count_d = env_count_q - 24'd1;
      end else begin
        env_count_d = env_len(regs_d[REG_ENV_FINE], regs_d[REG_ENV_COARSE]);
        if (!env_frozen_q) begin
          if (env_rising_q && env_level_q < LEVEL_MAX) begin
            env_level_d = env_level_q + 4'd1;
          end else if (!env_rising_q && env_level_q > 4'd0) begin
            env_level_d = env_level_q - 4'd1;
          end else if (!env_shape_q[ShapeCont]) begin
            env_level_d  = 4'd0;
            env_frozen_d = 1'b1;
          end else if (env_shape_q[ShapeHold]) begin
            env_level_d  = ((env_shape_q[ShapeAlt] ^ attack) == 1'b1) ? LEVEL_MAX : 4'd0;
            env_frozen_d = 1'b1;
          end else begin
            if (env_shape_q[ShapeAlt]) begin
              dir = !env_rising_q;
            end
            env_rising_d = dir;
            env_level_d  = dir ? 4'd0 : LEVEL_MAX;
          end
        end
      end
    end
    if (do_write && (sel_reg_q == REG_ENV_FINE || sel_reg_q == REG_ENV_COARSE)) begin
      env_count_d = env_len(regs_d[REG_ENV_FINE], regs_d[REG_ENV_COARSE]);
    end
    if (do_write && sel_reg_q == REG_ENV_SHAPE) begin
      env_count_d  = env_len(regs_d[REG_ENV_FINE], regs_d[REG_ENV_COARSE]);
      env_shape_d  = {wr_val[3], wr_val[1], wr_val[0]};
      env_rising_d = wr_val[ShapeAttack];
      env_level_d  = wr_val[ShapeAttack] ? 4'd0 : LEVEL_MAX;
      env_frozen_d = 1'b0;
    end
  end

  // gated voice levels from the updated state
  always_comb begin
    logic       tg;
    logic       ng;
    logic [7:0] vr;
    for (int c = 0; c < NumVoices; c++) begin
      tg = regs_d[REG_MIXER][c] | tone_bit_d[c];
      ng = regs_d[REG_MIXER][c+NoiseVoiceOfs] | noise_bit_d;
      vr = regs_d[4'(REG_VOL_A + 4'(c))];
      lvl_d[c] = vr[VolEnvBit] ? env_level_d : vr[3:0];
      if (!(tg && ng)) begin
        lvl_d[c] = 4'd0;
      end
    end
  end

  assign mix_sum  = 18'(vol_lookup(s1_lvl_q[0])) + 18'(vol_lookup(s1_lvl_q[1]))
                  + 18'(vol_lookup(s1_lvl_q[2]));
  assign mix_prod = mix_sum * MIX_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) begin
        regs_q[r] <= 8'h00;
      end
      for (int c = 0; c < NumVoices; c++) begin
        tone_count_q[c] <= TONE_RESET;
      end
      sel_reg_q     <= 4'd0;
      sel_valid_q   <= 1'b0;
      active_q      <= 1'b0;
      tone_bit_q    <= 3'b111;
      noise_count_q <= NOISE_RESET;
      noise_shift_q <= NOISE_SEED;
      noise_bit_q   <= 1'b1;
      env_count_q   <= ENV_RESET;
      env_level_q   <= LEVEL_MAX;
      env_rising_q  <= 1'b0;
      env_shape_q   <= 3'b000;
      env_frozen_q  <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      regs_d_copy: for (int r = 0; r < NumRegs; r++) begin
        regs_q[r] <= regs_d[r];
      end
      for (int c = 0; c < NumVoices; c++) begin
        tone_count_q[c] <= tone_count_d[c];
      end
      sel_reg_q     <= sel_reg_d;
      sel_valid_q   <= sel_valid_d;
      active_q      <= active_d;
      tone_bit_q    <= tone_bit_d;
      noise_count_q <= noise_count_d;
      noise_shift_q <= noise_shift_d;
      noise_bit_q   <= noise_bit_d;
      env_count_q   <= env_count_d;
      env_level_q   <= env_level_d;
      env_rising_q  <= env_rising_d;
      env_shape_q   <= env_shape_d;
      env_frozen_q  <= env_frozen_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_rd_q     <= rd_val;
      s1_active_q <= active_d;
      for (int c = 0; c < NumVoices; c++) begin
        s1_lvl_q[c] <= lvl_d[c];
      end
    end
    if (s1_advance) begin
      out_q.read_data    <= s1_rd_q;
      out_q.level_a      <= s1_lvl_q[0];
      out_q.level_b      <= s1_lvl_q[1];
      out_q.level_c      <= s1_lvl_q[2];
      out_q.mixed_sample <= mix_prod[MixShift +: 16];
      out_q.is_active    <= s1_active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_noise_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_shift_q != 17'd0)
    else $error("noise shift register reached zero");

  a_tone_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_count_q[0] != 16'd0 && tone_count_q[1] != 16'd0 && tone_count_q[2] != 16'd0)
    else $error("tone counter reached zero");

  a_frozen_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_frozen_q |-> (env_level_q == 4'd0 || env_level_q == LEVEL_MAX))
    else $error("envelope frozen at an intermediate level");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_stall_i |=> out_valid_q)
    else $error("level stage did not reach the output register");

endmodule
